### hdl/iap_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII padded formatter.
// Used by every module of the block; depends on nothing.
package iap_pkg;

   // Fixed width of the value field on the request port.
   localparam int VALUE_W    = 32;
   // Bits of the value that take part in formatting.
   localparam int VALUE_BITS = 32;
   // Largest honored field width; wider requests saturate to it.
   localparam int MAX_WIDTH  = 64;
   // Fixed width of the min_width field on the request port.
   localparam int MINW_W     = 7;

   localparam int RADIX_DEC  = 10;
   // Decimal digits of the largest value: floor(bits * log10(2)) + 1.
   localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DIG_W      = NDIG * 4;
   localparam int IDX_W      = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int PAD_W      = $clog2(MAX_WIDTH + 1);

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      OP_UDEC = 2'd0,
      OP_SDEC = 2'd1,
      OP_LHEX = 2'd2,
      OP_UHEX = 2'd3
   } op_type;

   // One classified transaction as it waits in the queue.
   typedef struct packed {
      logic [VALUE_BITS-1:0] mag;
      logic                  neg;
      logic                  hex;
      logic                  upper;
      logic [PAD_W-1:0]      width;
      logic [7:0]            fill;
   } iap_item_type;

   function automatic logic [7:0] digit_char(input logic [3:0] dgt, input logic upper);
      logic [7:0] base_ch;
      base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
      if (dgt < 4'(RADIX_DEC)) begin
         return CH_ZERO + 8'(dgt);
      end
      return base_ch + 8'(dgt) - 8'(RADIX_DEC);
   endfunction

endpackage

### hdl/iap_front.sv
// Front end: accepts a request and classifies it into a queue entry.
// Depends on iap_pkg.
module iap_front (
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_op,
   input  logic [iap_pkg::VALUE_W-1:0] req_value,
   input  logic [iap_pkg::MINW_W-1:0] req_min_width,
   input  logic                       req_zero_pad,
   output logic                       push,
   output iap_pkg::iap_item_type      push_item
);
   import iap_pkg::*;

   logic [VALUE_BITS-1:0] val;
   op_type                op;

   assign push = start & ~busy;
   assign op   = op_type'(req_op);
   assign val  = req_value[VALUE_BITS-1:0];

   always_comb begin
      push_item.neg   = 1'b0;
      push_item.hex   = 1'b0;
      push_item.upper = 1'b0;
      push_item.mag   = val;
      unique case (op)
         OP_UDEC: begin
            push_item.hex = 1'b0;
         end
         OP_SDEC: begin
            // Negation in VALUE_BITS bits also gives the right magnitude
            // for the most negative value.
            if (val[VALUE_BITS-1]) begin
               push_item.neg = 1'b1;
               push_item.mag = ~val + VALUE_BITS'(1);
            end
         end
         OP_LHEX: begin
            push_item.hex = 1'b1;
         end
         OP_UHEX: begin
            push_item.hex   = 1'b1;
            push_item.upper = 1'b1;
         end
         default: begin
            push_item.hex = 1'b0;
         end
      endcase
      if (req_min_width > MINW_W'(MAX_WIDTH)) begin
         push_item.width = PAD_W'(MAX_WIDTH);
      end else begin
         push_item.width = PAD_W'(req_min_width);
      end
      push_item.fill = req_zero_pad ? CH_ZERO : CH_SPACE;
   end

endmodule

### hdl/iap_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on iap_pkg for the entry type.
module iap_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  iap_pkg::iap_item_type push_item,
   input  logic                  pop,
   output iap_pkg::iap_item_type head_item,
   output logic                  empty,
   output logic                  full
);
   import iap_pkg::*;

   iap_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/iap_back.sv
// Back end: converts one queued number to digits and emits its characters.
// Depends on iap_pkg.
module iap_back (
   input  logic                  clock,
   input  logic                  reset,
   input  iap_pkg::iap_item_type head_item,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);
   import iap_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  upper_ff, upper_in;
   logic [PAD_W-1:0]      width_ff, width_in;
   logic [7:0]            fill_ff, fill_in;
   logic [PAD_W-1:0]      pad_ff, pad_in;
   logic                  sign_ff, sign_in;
   logic [IDX_W-1:0]      dpos_ff, dpos_in;
   logic                  strobe_ff, strobe_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic [DIG_W-1:0]      bcd_adj;
   logic [IDX_W-1:0]      top;
   logic [PAD_W-1:0]      len;

   assign pop           = (state_ff == ST_IDLE) && !empty;
   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // Add-3 correction of every BCD digit before the next shift.
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // Most significant nonzero digit; zero has one digit.
   always_comb begin
      top = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            top = IDX_W'(i);
         end
      end
      len = PAD_W'(top) + PAD_W'(1) + PAD_W'(neg_ff);
   end

   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      upper_in  = upper_ff;
      width_in  = width_ff;
      fill_in   = fill_ff;
      pad_in    = pad_ff;
      sign_in   = sign_ff;
      dpos_in   = dpos_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               bin_in   = head_item.mag;
               neg_in   = head_item.neg;
               upper_in = head_item.upper;
               width_in = head_item.width;
               fill_in  = head_item.fill;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               if (head_item.hex) begin
                  bcd_in   = DIG_W'(head_item.mag);
                  state_in = ST_SIZE;
               end else begin
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            pad_in   = (width_ff > len) ? (width_ff - len) : '0;
            sign_in  = neg_ff;
            dpos_in  = top;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (pad_ff != '0) begin
               char_in = fill_ff;
               pad_in  = pad_ff - PAD_W'(1);
            end else if (sign_ff) begin
               char_in = CH_MINUS;
               sign_in = 1'b0;
            end else begin
               char_in = digit_char(bcd_ff[dpos_ff*4 +: 4], upper_ff);
               dpos_in = dpos_ff - IDX_W'(1);
               if (dpos_ff == '0) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
      width_ff <= width_in;
      fill_ff  <= fill_in;
      pad_ff   <= pad_in;
      sign_ff  <= sign_in;
      dpos_ff  <= dpos_in;
      char_ff  <= char_in;
   end

endmodule

### hdl/integer_to_ascii_padded_unit.sv
// Top level of the integer-to-ASCII padded formatter.
// Depends on iap_pkg, iap_front, iap_queue and iap_back.
//
//   Channel   Handshake              Payload ports
//   request   start, busy            req_op, req_value, req_min_width, req_zero_pad
//   response  rsp_strobe (1 cycle)   rsp_character, rsp_last
//
// A request transaction is taken at a rising edge with start high and busy low.
// With the back end idle, a decimal transaction first passes through the
// shift-and-add-3 converter, which handles one value bit per cycle, and then the
// sizing state; a hex transaction goes straight to sizing. Then one character
// leaves per cycle, and the back end takes no new transaction until the last
// character of the current one has left.
// A two-entry queue lets new transactions arrive while one is converting or
// emitting; busy is high while the queue is full.
// Reset is synchronous and active high; it empties the queue and idles the back end.
// The receiver cannot stall: every response is valid for exactly one cycle.
module integer_to_ascii_padded_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [iap_pkg::VALUE_W-1:0] req_value,
   input  logic [iap_pkg::MINW_W-1:0]  req_min_width,
   input  logic                        req_zero_pad,
   output logic                        rsp_strobe,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);
   import iap_pkg::*;

   logic         queue_push;
   logic         queue_pop;
   logic         queue_empty;
   logic         queue_full;
   iap_item_type push_item;
   iap_item_type head_item;

   // The front end can accept a transaction whenever the queue has room.
   assign busy = queue_full;

   iap_front u_front (
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_min_width (req_min_width),
      .req_zero_pad  (req_zero_pad),
      .push          (queue_push),
      .push_item     (push_item)
   );

   iap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .pop       (queue_pop),
      .head_item (head_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   iap_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .empty         (queue_empty),
      .pop           (queue_pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // The back end never takes an entry from an empty queue.
   assert property (@(posedge clock) disable iff (reset) queue_pop |-> !queue_empty)
      else $error("back end popped an empty queue");

   // The final character of a transaction is always carried by a strobe.
   assert property (@(posedge clock) disable iff (reset) rsp_last |-> rsp_strobe)
      else $error("last flag without strobe");

   // After the final character the back end must reload before emitting again.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("character emitted right after the last one");

   // Reset leaves no response on the port.
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe active right after reset");

endmodule

### dv/iap_text_checker.sv
// Checker for the integer-to-ASCII padded formatter: watches both channels,
// predicts the text of every accepted number and compares each character.
// Depends on iap_pkg for the operation codes, widths and character constants.
module iap_text_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [iap_pkg::VALUE_W-1:0] req_value,
   input  logic [iap_pkg::MINW_W-1:0]  req_min_width,
   input  logic                        req_zero_pad,
   input  logic                        rsp_strobe,
   input  logic [7:0]                  rsp_character,
   input  logic                        rsp_last,
   output int                          mismatch_count,
   output int                          pending_chars,
   output int                          numbers_accepted,
   output int                          chars_checked
);
   import iap_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];

   // Appends the characters that one number turns into, pad characters first.
   function automatic void predict_text(input op_type op, input logic [VALUE_W-1:0] value,
                                        input logic [MINW_W-1:0] min_w,
                                        input logic zero_pad);
      logic [VALUE_BITS-1:0] mag;
      logic [7:0]            digits[$];
      logic [3:0]            nibble;
      logic [7:0]            fill;
      logic                  negative;
      int unsigned           radix;
      int                    field_w;
      int                    pad_count;
      int                    total;
      text_char_type         entry;
      mag      = value[VALUE_BITS-1:0];
      negative = (op == OP_SDEC) && mag[VALUE_BITS-1];
      radix    = (op == OP_LHEX || op == OP_UHEX) ? 16 : RADIX_DEC;
      fill     = zero_pad ? CH_ZERO : CH_SPACE;
      // The negated most negative value reads correctly as an unsigned magnitude.
      if (negative) begin
         mag = -mag;
      end
      do begin
         nibble = 4'(mag % radix);
         if (nibble < 4'(RADIX_DEC)) begin
            digits.push_front(CH_ZERO + 8'(nibble));
         end else begin
            digits.push_front(((op == OP_UHEX) ? CH_UPPER_A : CH_LOWER_A)
                              + 8'(nibble) - 8'(RADIX_DEC));
         end
         mag = mag / radix;
      end while (mag != 0);
      if (negative) begin
         digits.push_front(CH_MINUS);
      end
      field_w   = (min_w > MAX_WIDTH) ? MAX_WIDTH : int'(min_w);
      pad_count = (field_w > digits.size()) ? field_w - digits.size() : 0;
      total     = pad_count + digits.size();
      for (int k = 0; k < total; k++) begin
         entry.character = (k < pad_count) ? fill : digits[k - pad_count];
         entry.last      = (k == total - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // Responses are compared before the request of the same edge is predicted,
   // so a character can never be matched against the number just accepted.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            chars_checked <= chars_checked + 1;
            if (expected_text.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("ERROR: unexpected character 8'h%02h last %0b", rsp_character,
                           rsp_last);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character || rsp_last !== want.last) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("ERROR: char expected 8'h%02h got 8'h%02h, last %0b got %0b",
                              want.character, rsp_character, want.last, rsp_last);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (start && !busy) begin
            predict_text(op_type'(req_op), req_value, req_min_width, req_zero_pad);
            numbers_accepted <= numbers_accepted + 1;
         end
      end
      pending_chars <= expected_text.size();
   end

endmodule

### dv/tb_integer_to_ascii_padded_unit.sv
// Top of the testbench for integer_to_ascii_padded_unit: drives request
// transactions and gives the verdict. Depends on iap_pkg and iap_text_checker.
module tb_integer_to_ascii_padded_unit;
   import iap_pkg::*;

   // Number of random transactions after the directed ones.
   localparam int RANDOM_NUMBERS = 160;
   // Cycles allowed after the last character before the verdict.
   localparam int DRAIN_CYCLES   = 40;

   logic               clock;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic               busy;
   logic [1:0]         req_op        = '0;
   logic [VALUE_W-1:0] req_value     = '0;
   logic [MINW_W-1:0]  req_min_width = '0;
   logic               req_zero_pad  = 1'b0;
   logic               rsp_strobe;
   logic [7:0]         rsp_character;
   logic               rsp_last;

   int mismatch_count;
   int pending_chars;
   int numbers_accepted;
   int chars_checked;

   // When set, the request side sends back to back with no idle cycles.
   bit quiet_stretch = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   integer_to_ascii_padded_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .req_min_width (req_min_width),
      .req_zero_pad  (req_zero_pad),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   iap_text_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_min_width    (req_min_width),
      .req_zero_pad     (req_zero_pad),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .pending_chars    (pending_chars),
      .numbers_accepted (numbers_accepted),
      .chars_checked    (chars_checked)
   );

   // Sends one number as a request transaction. The task is entered at a
   // rising edge and returns at the edge where the transaction was taken.
   // Before the transaction it may idle with start low; the idle decision
   // is made here, so start is only ever given one value per time step.
   // While busy is high, start and the fields simply stay put.
   task automatic send_number(input op_type op, input logic [VALUE_W-1:0] value,
                              input logic [MINW_W-1:0] min_w, input logic zero_pad);
      if (!quiet_stretch && $urandom_range(99) < 28) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_value     <= value;
      req_min_width <= min_w;
      req_zero_pad  <= zero_pad;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [MINW_W-1:0]  min_w;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every format, the most negative value,
      // widths above the bound, widths equal to or shorter than the text, and
      // zero width.
      send_number(OP_UDEC, 32'd0,          7'd0,   1'b0);
      send_number(OP_UDEC, 32'hFFFF_FFFF,  7'd0,   1'b0);
      send_number(OP_SDEC, 32'h8000_0000,  7'd0,   1'b1);
      send_number(OP_SDEC, -32'sd42,       7'd5,   1'b1);
      send_number(OP_SDEC, 32'h7FFF_FFFF,  7'd11,  1'b0);
      send_number(OP_SDEC, 32'hFFFF_FFFF,  7'd64,  1'b0);
      send_number(OP_SDEC, 32'hFFFF_FFFF,  7'd0,   1'b1);
      send_number(OP_LHEX, 32'hDEAD_BEEF,  7'd0,   1'b0);
      send_number(OP_UHEX, 32'hABCD_EF01,  7'd10,  1'b1);
      send_number(OP_LHEX, 32'd0,          7'd1,   1'b1);
      send_number(OP_UHEX, 32'hFFFF_FFFF,  7'd127, 1'b1);
      send_number(OP_UDEC, 32'd12345,      7'd65,  1'b0);
      send_number(OP_UDEC, 32'd7,          7'd64,  1'b1);
      send_number(OP_UDEC, 32'd100,        7'd3,   1'b1);
      send_number(OP_SDEC, 32'd5,          7'd2,   1'b0);
      send_number(OP_LHEX, 32'h0000_000A,  7'd100, 1'b0);
      send_number(OP_UHEX, 32'h0000_0001,  7'd63,  1'b1);
      send_number(OP_UDEC, 32'd1000000000, 7'd10,  1'b1);
      send_number(OP_SDEC, 32'h8000_0000,  7'd12,  1'b0);

      // Random part. Widths are mostly short so most transactions are
      // dominated by the digits; some reach the bound and some saturate.
      // A stretch in the middle runs with no idle cycles to keep the
      // internal queue full.
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         quiet_stretch = (n >= 60 && n < 110);
         op = op_type'($urandom_range(3));
         case ($urandom_range(4))
            0: value = $urandom;
            1: value = $urandom_range(999);
            2: value = $urandom >> $urandom_range(31);
            // Values around the sign boundary.
            3: value = 32'h8000_0000 + $urandom_range(4) - 2;
            default: value = ~$urandom_range(255);
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: min_w = MINW_W'($urandom_range(12));
            6, 7, 8: min_w = MINW_W'($urandom_range(MAX_WIDTH));
            default: min_w = MINW_W'($urandom_range(127, MAX_WIDTH + 1));
         endcase
         send_number(op, value, min_w, 1'($urandom_range(1)));
      end
      start <= 1'b0;
      quiet_stretch = 1'b0;

      // Every number produces at least one character, so once the checker has
      // nothing left pending the block has finished; a short drain then
      // catches any stray characters.
      do @(posedge clock); while (pending_chars != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d numbers in unsigned, signed, lower and upper hex forms,",
               numbers_accepted);
      $display("with widths from zero to beyond the bound; %0d characters compared.",
               chars_checked);
      if (mismatch_count == 0 && pending_chars == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("Timeout with %0d characters still expected", pending_chars);
      $display("== FAIL ==");
      $finish;
   end

endmodule

### integer_to_ascii_padded_unit.f
hdl/iap_pkg.sv
hdl/iap_front.sv
hdl/iap_queue.sv
hdl/iap_back.sv
hdl/integer_to_ascii_padded_unit.sv
dv/iap_text_checker.sv
dv/tb_integer_to_ascii_padded_unit.sv
